// ----- rtl/bffa_pkg.sv -----
`timescale 1ns / 1ps

package bffa_pkg;

   // Operation codes of a request word.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [6:0] block_count;
      logic [5:0] first_block;
   } req_word_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] start_index;
   } rsp_word_type;

   // Broadcast from the controller to every cell of the map.
   typedef struct packed {
      logic       shift;
      logic       mark;
      logic       free_en;
      logic       clear_all;
      logic [6:0] count;
      logic [5:0] first;
   } cell_ctrl_type;

endpackage

// ----- rtl/bffa_cell.sv -----
`timescale 1ns / 1ps

module bffa_cell
   import bffa_pkg::*;
#(
   parameter int BLOCK_COUNT = 64,
   parameter int CELL_IDX    = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          right_bit,
   output logic          used_bit
);

   localparam int IDX_W = $clog2(BLOCK_COUNT);
   localparam int CW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

   logic [CW-1:0] pos;
   logic          mark_hit;
   logic          free_hit;
   logic          used_ff;
   logic          used_in;

   assign pos = CW'(CELL_IDX);

   // After the shift this cell holds one of the last count blocks scanned.
   assign mark_hit = (pos + CW'(ctrl.count)) >= CW'(BLOCK_COUNT);
   assign free_hit = (pos >= CW'(ctrl.first)) &&
                     (pos < (CW'(ctrl.first) + CW'(ctrl.count)));

   always_comb begin
      used_in = used_ff;
      if (ctrl.clear_all) begin
         used_in = 1'b0;
      end else if (ctrl.shift) begin
         used_in = (ctrl.mark && mark_hit) ? 1'b1 : right_bit;
      end else if (ctrl.free_en && free_hit) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign used_bit = used_ff;

endmodule

// ----- rtl/bffa_ctrl.sv -----
`timescale 1ns / 1ps

module bffa_ctrl
   import bffa_pkg::*;
#(
   parameter int BLOCK_COUNT = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_word_type  req_data,
   output logic          rsp_valid,
   output rsp_word_type  rsp_data,
   input  logic          head_bit,
   output cell_ctrl_type ctrl
);

   localparam int IDX_W = $clog2(BLOCK_COUNT);
   localparam int AW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [6:0]       run_ff, run_in;
   logic [6:0]       count_ff, count_in;
   logic             found_ff, found_in;
   logic [5:0]       start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   logic             accept;
   logic             scanning;
   logic             last_step;
   logic             count_fits;
   logic             free_ok;
   logic [6:0]       run_next;
   logic             hit;
   logic [AW-1:0]    hit_start;

   assign accept    = start && (state_ff == ST_IDLE);
   assign scanning  = (state_ff == ST_SCAN);
   assign last_step = (step_ff == IDX_W'(BLOCK_COUNT - 1));

   assign count_fits = (req_data.block_count != 7'd0) &&
                       (AW'(req_data.block_count) <= AW'(BLOCK_COUNT));
   assign free_ok    = (req_data.block_count != 7'd0) &&
                       ((AW'(req_data.first_block) + AW'(req_data.block_count))
                        <= AW'(BLOCK_COUNT));

   assign run_next  = head_bit ? 7'd0 : (run_ff + 7'd1);
   assign hit       = scanning && !found_ff && !head_bit && (run_next == count_ff);
   assign hit_start = AW'(step_ff) + AW'(1) - AW'(count_ff);

   always_comb begin
      ctrl.shift     = scanning;
      ctrl.mark      = hit;
      ctrl.free_en   = accept && (req_data.operation == OP_FREE);
      ctrl.clear_all = accept && (req_data.operation == OP_CLEAR);
      ctrl.count     = scanning ? count_ff : req_data.block_count;
      ctrl.first     = req_data.first_block;
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      run_in           = run_ff;
      count_in         = count_ff;
      found_in         = found_ff;
      start_in         = start_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.ok          = 1'b0;
               rsp_in.start_index = 6'd0;
               case (req_data.operation)
                  OP_ALLOC: begin
                     if (count_fits) begin
                        state_in = ST_SCAN;
                        step_in  = '0;
                        run_in   = 7'd0;
                        count_in = req_data.block_count;
                        found_in = 1'b0;
                        start_in = 6'd0;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.ok    = free_ok;
                  end
                  OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.ok    = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            step_in = step_ff + IDX_W'(1);
            if (!found_ff) begin
               run_in = run_next;
            end
            if (hit) begin
               found_in = 1'b1;
               start_in = hit_start[5:0];
            end
            if (last_step) begin
               state_in           = ST_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = found_in;
               rsp_in.start_index = found_in ? start_in : 6'd0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         run_ff       <= 7'd0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         run_ff       <= run_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      start_ff <= start_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = scanning;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while scanning");

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || scanning))
      else $error("accepted word neither answered nor scanning");

   a_found_sticks: assert property (@(posedge clock) disable iff (reset)
      (scanning && found_ff && !last_step) |=> found_ff)
      else $error("found flag dropped mid scan");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      (scanning && !found_ff) |-> (run_ff < count_ff))
      else $error("free run passed requested count");
`endif

endmodule

// ----- rtl/bitmap_first_fit_block_allocator.sv -----
`timescale 1ns / 1ps

// First-fit contiguous block allocator over a bitmap of BLOCK_COUNT used marks.
// Request word (req_data) is taken at a clock edge with start high and busy low.
//   allocate: find the lowest run of block_count free blocks, mark it used,
//             return its start block; ok low on zero count or no fitting run.
//   free:     clear block_count marks from first_block; a run that passes the
//             end of the map is clipped and answered with ok low.
//   clear:    mark every block free, ok high.
// Each result word appears on rsp_data for exactly one cycle with rsp_valid
// high; the receiver cannot stall, so results are never held back.
// The map lives in a ring of one-bit cells. An allocation rotates the ring one
// full turn past the scanner at cell 0, one block per cycle, and marks the run
// in the cells just passed when it completes; the result comes at the end of
// the turn, and busy stays high until then, so no new word is taken during a
// scan. Free, clear, a zero or oversize count and an unknown operation are
// answered in the cycle after accept without a scan, busy stays low.
// Reset (synchronous) frees every block and drops any scan in progress.

module bitmap_first_fit_block_allocator
   import bffa_pkg::*;
#(
   parameter int BLOCK_COUNT = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_data
);

   // Cell k holds the mark of block (k + turn offset); idle offset is zero.
   logic [BLOCK_COUNT-1:0] map_bit;
   cell_ctrl_type          ctrl;

   bffa_ctrl #(
      .BLOCK_COUNT(BLOCK_COUNT)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .head_bit (map_bit[0]),
      .ctrl     (ctrl)
   );

   // Advance every mark one cell toward the scanner; cell 0 feeds the tail.
   for (genvar k = 0; k < BLOCK_COUNT; k++) begin : g_cell
      bffa_cell #(
         .BLOCK_COUNT(BLOCK_COUNT),
         .CELL_IDX   (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .right_bit(map_bit[(k + 1) % BLOCK_COUNT]),
         .used_bit (map_bit[k])
      );
   end

endmodule

// ----- sim/allocation_checker.sv -----
`timescale 1ns / 1ps

module allocation_checker
   import bffa_pkg::*;
#(
   parameter int BLOCK_COUNT = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  rsp_word_type rsp_data,
   output int           mismatch_count,
   output int           pending_count,
   output int           checked_count,
   output int           grant_count
);

   localparam int REPORT_LIMIT = 10;

   bit [BLOCK_COUNT-1:0] used_marks;
   rsp_word_type         expected_words[$];

   // Work out the answer to one request word and update the used marks.
   function automatic rsp_word_type predict_allocation(input req_word_type word);
      rsp_word_type answer;
      int           run_len;
      int           idx;
      int           base;
      int           k;
      bit           clipped;
      answer  = '0;
      run_len = 0;
      clipped = 1'b0;
      case (word.operation)
         OP_ALLOC: begin
            if (word.block_count != 0 && word.block_count <= BLOCK_COUNT) begin
               for (idx = 0; idx < BLOCK_COUNT && !answer.ok; idx++) begin
                  if (used_marks[idx]) begin
                     run_len = 0;
                  end else begin
                     run_len++;
                     if (run_len == word.block_count) begin
                        base = idx + 1 - run_len;
                        for (k = base; k <= idx; k++)
                           used_marks[k] = 1'b1;
                        answer.ok          = 1'b1;
                        answer.start_index = base[5:0];
                     end
                  end
               end
            end
         end
         OP_FREE: begin
            if (word.block_count != 0) begin
               for (k = 0; k < word.block_count && !clipped; k++) begin
                  idx = int'(word.first_block) + k;
                  if (idx >= BLOCK_COUNT)
                     clipped = 1'b1;
                  else
                     used_marks[idx] = 1'b0;
               end
               answer.ok = !clipped;
            end
         end
         OP_CLEAR: begin
            used_marks = '0;
            answer.ok  = 1'b1;
         end
         default: begin
            answer = '0;
         end
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_word_type expected;
      if (reset) begin
         used_marks = '0;
         expected_words.delete();
         mismatch_count = 0;
         checked_count  = 0;
         grant_count    = 0;
      end else begin
         if (start && !busy)
            expected_words.push_back(predict_allocation(req_data));
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result word ok=%0b start_index=%0d",
                           $realtime, rsp_data.ok, rsp_data.start_index);
            end else begin
               expected = expected_words.pop_front();
               checked_count++;
               if (expected.ok)
                  grant_count++;
               if (rsp_data.ok !== expected.ok
                   || rsp_data.start_index !== expected.start_index) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: result mismatch: expected ok=%0b start_index=%0d,",
                               " got ok=%0b start_index=%0d"},
                              $realtime, expected.ok, expected.start_index,
                              rsp_data.ok, rsp_data.start_index);
               end
            end
         end
      end
      pending_count = expected_words.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import bffa_pkg::*;

   localparam int         BLOCK_COUNT  = 64;
   localparam int         RANDOM_WORDS = 780;
   // Longest quiet stretch in a correct run is an idle gap plus one scan.
   localparam int         STALL_LIMIT  = 2000;
   localparam logic [1:0] OP_UNKNOWN   = 2'd3;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_data;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int grant_count;
   int op_totals[4];
   int stall_cycles;
   bit idle_enable;

   bitmap_first_fit_block_allocator #(
      .BLOCK_COUNT(BLOCK_COUNT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   allocation_checker #(
      .BLOCK_COUNT(BLOCK_COUNT)
   ) allocation_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .grant_count   (grant_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Present one request word at a falling edge and hold it until taken.
   // Called at a falling edge; returns at the falling edge after the accept,
   // with start still high so a back-to-back word follows without a gap.
   task automatic issue_word(input logic [1:0] operation, input int count,
                             input int first);
      int gap;
      gap = idle_enable ? $urandom_range(19, 0) : 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.operation   = operation;
      req_data.block_count = count[6:0];
      req_data.first_block = first[5:0];
      start = 1'b1;
      op_totals[operation]++;
      // The word is taken at the first rising edge that sees busy low.
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
   endtask

   initial begin
      int         n;
      int         pick;
      int         count;
      int         first;
      logic [1:0] operation;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      idle_enable = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: edges of the fields and every corner of the map.
      issue_word(OP_ALLOC, 0, 0);        // zero count is refused
      issue_word(OP_ALLOC, 64, 0);       // whole pool at once
      issue_word(OP_ALLOC, 1, 0);        // pool full, no fit
      issue_word(OP_FREE, 64, 0);        // release everything exactly
      issue_word(OP_ALLOC, 65, 0);       // one past the pool size
      issue_word(OP_ALLOC, 127, 63);     // all-ones count
      issue_word(OP_ALLOC, 1, 0);
      issue_word(OP_ALLOC, 3, 0);
      issue_word(OP_ALLOC, 60, 0);       // fill the tail, map full again
      issue_word(OP_FREE, 2, 1);         // open a two-block hole
      issue_word(OP_ALLOC, 3, 0);        // hole too short
      issue_word(OP_ALLOC, 2, 0);        // hole fits exactly
      issue_word(OP_FREE, 0, 5);         // zero count free
      issue_word(OP_FREE, 1, 63);        // last block alone
      issue_word(OP_FREE, 10, 60);       // run past the end is clipped
      issue_word(OP_FREE, 127, 63);      // clipped, all-ones fields
      issue_word(OP_FREE, 2, 60);        // blocks already free stay free
      issue_word(OP_ALLOC, 4, 0);        // lands at the top of the map
      issue_word(OP_UNKNOWN, 42, 21);    // unknown operation is ignored
      issue_word(OP_CLEAR, 85, 42);      // clear ignores its fields
      issue_word(OP_ALLOC, 64, 0);
      issue_word(OP_UNKNOWN, 127, 63);
      issue_word(OP_CLEAR, 0, 0);
      issue_word(OP_FREE, 64, 63);       // clipped from the last block
      issue_word(OP_ALLOC, 1, 0);

      // Random part: mostly small allocations and frees so the map fragments,
      // with oversize counts, clears and unknown words mixed in.
      for (n = 0; n < RANDOM_WORDS; n++) begin
         // Toggle idle gaps in stretches; one stretch in three runs flat out.
         if (n % 100 == 0)
            idle_enable = ((n / 100) % 3) != 2;
         pick  = $urandom_range(99, 0);
         first = $urandom_range(63, 0);
         if (pick < 50) begin
            operation = OP_ALLOC;
            if (pick < 42)
               count = $urandom_range(8, 1);
            else if (pick < 47)
               count = $urandom_range(64, 9);
            else
               count = $urandom_range(127, 0);
         end else if (pick < 92) begin
            operation = OP_FREE;
            count = (pick < 85) ? $urandom_range(8, 1) : $urandom_range(127, 0);
         end else if (pick < 96) begin
            operation = OP_CLEAR;
            count = $urandom_range(127, 0);
         end else begin
            operation = OP_UNKNOWN;
            count = $urandom_range(127, 0);
         end
         issue_word(operation, count, first);
      end
      start = 1'b0;

      // Drain: wait for every result, then allow one more full scan.
      while (pending_count != 0)
         @(negedge clock);
      repeat (BLOCK_COUNT + 4) @(posedge clock);

      $display("covered %0d request words: %0d allocate, %0d free, %0d clear, %0d unknown",
               op_totals[0] + op_totals[1] + op_totals[2] + op_totals[3],
               op_totals[OP_ALLOC], op_totals[OP_FREE], op_totals[OP_CLEAR],
               op_totals[OP_UNKNOWN]);
      $display("checked %0d result words, %0d successful, %0d mismatches",
               checked_count, grant_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
